### design/tst_pkg.sv
// ----------------------------------------------------------------------------
// tst_pkg
// Shared types, widths and the spline basis table for the trail tessellator.
// ----------------------------------------------------------------------------
package tst_pkg;

	localparam int COORD_W = 32;
	localparam int NCOORD  = 6;
	localparam int PT_W    = COORD_W * NCOORD;
	localparam int LIFE_W  = 22;
	localparam int TEXV_W  = 18;
	localparam int IN_W    = 216;
	localparam int OUT_W   = 232;
	localparam int K_W     = 3;
	localparam int WGT_W   = 9;
	localparam int PROD_W  = 41;
	localparam int SUM_W   = 43;
	localparam int RND_SH  = 7;

	localparam logic [K_W-1:0] K_LAST = 3'd4;

	typedef logic signed [COORD_W-1:0] coord_t;
	// coordinates 0..2 are the root point, 3..5 the tip point
	typedef coord_t [NCOORD-1:0] pt_t;
	typedef logic signed [WGT_W-1:0] wgt_t;
	typedef wgt_t [3:0] wrow_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	localparam sum_t RND_HALF = 43'sd64;

	typedef struct packed {
		logic           in_take;
		logic           win_load;
		logic           issue;
		logic           seg_end;
		logic           fetch;
		logic           last;
		logic [K_W-1:0] k;
	} tst_cmd_t;

	typedef struct packed {
		logic live;
		logic adv;
	} tst_sts_t;

	// catmull-rom weights at t = k/4, scaled by 128, element j weighs point j
	function automatic wrow_t basis_row(input logic [K_W-1:0] k);
		wrow_t r;
		unique case (k)
			3'd0: r = {9'sd0, 9'sd0, 9'sd128, 9'sd0};
			3'd1: r = {-9'sd3, 9'sd29, 9'sd111, -9'sd9};
			3'd2: r = {-9'sd8, 9'sd72, 9'sd72, -9'sd8};
			3'd3: r = {-9'sd9, 9'sd111, 9'sd29, -9'sd3};
			3'd4: r = {9'sd0, 9'sd128, 9'sd0, 9'sd0};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### design/tst_ctrl.sv
// ----------------------------------------------------------------------------
// tst_ctrl
// Sequencer: walks segments and sample points, drives the datapath commands.
// ----------------------------------------------------------------------------
module tst_ctrl #(
	parameter int SEGMENTS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  tst_pkg::tst_sts_t             sts,
	output tst_pkg::tst_cmd_t             cmd,
	output logic [$clog2(SEGMENTS)-1:0]   seg
);
	import tst_pkg::*;

	localparam int SEG_W = $clog2(SEGMENTS);
	localparam int CMP_W = SEG_W + 2;
	localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(SEGMENTS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;

	logic [1:0]       state_q;
	logic [SEG_W-1:0] seg_q;
	logic [K_W-1:0]   k_q;

	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		cmd.in_take   = s_axis_tvalid && s_axis_tready;
		cmd.win_load  = (state_q == ST_LOAD);
		cmd.issue     = (state_q == ST_RUN) && sts.adv;
		cmd.k         = k_q;
		cmd.seg_end   = cmd.issue && (k_q == K_LAST);
		cmd.last      = (seg_q == SEG_LAST) && (k_q == K_LAST);
		// a new far point exists only while segment + 3 is inside the history
		cmd.fetch     = (CMP_W'(seg_q) + CMP_W'(3)) < CMP_W'(SEGMENTS);
		seg           = seg_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seg_q   <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.in_take && sts.live) state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					seg_q   <= '0;
					k_q     <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (cmd.issue) begin
						if (k_q == K_LAST) begin
							k_q <= '0;
							if (seg_q == SEG_LAST) state_q <= ST_IDLE;
							else seg_q <= seg_q + 1'b1;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_last_ends_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue && cmd.last) |=> (state_q == ST_IDLE))
		else $error("sweep did not end after the last word");

	a_live_loads_window: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.in_take && sts.live) |=> cmd.win_load)
		else $error("live word did not load the window");

	a_stall_holds_position: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RUN) && !sts.adv) |=> ($stable(k_q) && $stable(seg_q)))
		else $error("sample position moved during a stall");

endmodule

### design/tst_datapath.sv
// ----------------------------------------------------------------------------
// tst_datapath
// Point histories, segment window, basis products, sum, round and saturate.
// ----------------------------------------------------------------------------
module tst_datapath #(
	parameter int SEGMENTS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tst_pkg::tst_cmd_t                cmd,
	output tst_pkg::tst_sts_t                sts,
	input  logic [$clog2(SEGMENTS)-1:0]      seg,
	input  logic [tst_pkg::IN_W-1:0]         s_axis_tdata,
	input  logic                             cfg_we,
	input  logic [tst_pkg::LIFE_W-1:0]       cfg_wdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [tst_pkg::OUT_W-1:0]        m_axis_tdata,
	output logic                             m_axis_tlast
);
	import tst_pkg::*;

	localparam int I2 = (SEGMENTS > 2) ? 2 : SEGMENTS - 1;
	localparam int P3 = (SEGMENTS > 3) ? 3 : SEGMENTS - 1;

	pt_t               hist_q [SEGMENTS];
	pt_t               win_q [4];
	logic [LIFE_W-1:0] lifetime_q;
	logic [LIFE_W-1:0] life_q;
	logic [LIFE_W-1:0] elapsed;
	logic [TEXV_W-1:0] tv_tab [SEGMENTS];
	wrow_t             wrow;
	logic              adv;

	prod_t             prod_s1 [NCOORD][4];
	logic [TEXV_W-1:0] tv_s1;
	logic [LIFE_W-1:0] life_s1;
	logic              last_s1;
	logic              v_s1;

	sum_t              sum_s2 [NCOORD];
	logic [TEXV_W-1:0] tv_s2;
	logic [LIFE_W-1:0] life_s2;
	logic              last_s2;
	logic              v_s2;

	pt_t               res_s3;
	logic [TEXV_W-1:0] tv_s3;
	logic [LIFE_W-1:0] life_s3;
	logic              last_s3;
	logic              v_s3;

	sum_t              rnd [NCOORD];
	pt_t               sat;

	// texture v per segment, rounded to nearest
	for (genvar g = 0; g < SEGMENTS; g++) begin : g_tv
		localparam int DEN = SEGMENTS - 1;
		localparam logic [TEXV_W-1:0] TV = TEXV_W'(((g + 1) * 131072 + DEN) / (2 * DEN));
		assign tv_tab[g] = TV;
	end

	assign elapsed  = s_axis_tdata[PT_W +: LIFE_W];
	assign adv      = !v_s3 || m_axis_tready;
	assign sts.adv  = adv;
	assign sts.live = lifetime_q > elapsed;
	assign wrow     = basis_row(cmd.k);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q <= '0;
		end else if (cfg_we) begin
			lifetime_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_take) life_q <= lifetime_q - elapsed;
	end

	// shift in on a new word; rotate once per segment so taps stay fixed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < SEGMENTS; j++) hist_q[j] <= '0;
		end else if (cmd.in_take) begin
			hist_q[0] <= pt_t'(s_axis_tdata[PT_W-1:0]);
			for (int j = 1; j < SEGMENTS; j++) hist_q[j] <= hist_q[j-1];
		end else if (cmd.seg_end) begin
			for (int j = 0; j < SEGMENTS - 1; j++) hist_q[j] <= hist_q[j+1];
			hist_q[SEGMENTS-1] <= hist_q[0];
		end
	end

	// four control points of the current segment, end points clamped
	always_ff @(posedge clk) begin
		if (cmd.win_load) begin
			win_q[0] <= hist_q[0];
			win_q[1] <= hist_q[0];
			win_q[2] <= hist_q[1];
			win_q[3] <= hist_q[I2];
		end else if (cmd.seg_end) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= win_q[3];
			if (cmd.fetch) win_q[3] <= hist_q[P3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && cmd.issue) begin
			for (int c = 0; c < NCOORD; c++) begin
				for (int j = 0; j < 4; j++) begin
					prod_s1[c][j] <= PROD_W'(wrow[j]) * PROD_W'(win_q[j][c]);
				end
			end
			tv_s1   <= tv_tab[seg];
			life_s1 <= life_q;
			last_s1 <= cmd.last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			for (int c = 0; c < NCOORD; c++) begin
				sum_s2[c] <= SUM_W'(prod_s1[c][0]) + SUM_W'(prod_s1[c][1]) +
				             SUM_W'(prod_s1[c][2]) + SUM_W'(prod_s1[c][3]);
			end
			tv_s2   <= tv_s1;
			life_s2 <= life_s1;
			last_s2 <= last_s1;
		end
	end

	// divide by 128 rounding half up, then clamp to the signed 32-bit range
	always_comb begin
		for (int c = 0; c < NCOORD; c++) begin
			rnd[c] = (sum_s2[c] + RND_HALF) >>> RND_SH;
			if ((rnd[c][SUM_W-1:COORD_W-1] == '0) || (rnd[c][SUM_W-1:COORD_W-1] == '1))
				sat[c] = rnd[c][COORD_W-1:0];
			else if (rnd[c][SUM_W-1])
				sat[c] = {1'b1, {(COORD_W-1){1'b0}}};
			else
				sat[c] = {1'b0, {(COORD_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			res_s3  <= sat;
			tv_s3   <= tv_s2;
			life_s3 <= life_s2;
			last_s3 <= last_s2;
		end
	end

	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata  = {life_s3, tv_s3, res_s3};
	assign m_axis_tlast  = last_s3;

	a_s2_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && adv) |=> v_s3)
		else $error("word lost between sum and output stage");

endmodule

### design/trail_spline_tessellator.sv
// a live input word loads the window, then each sample passes the product, sum and
// round/saturate registers to m_axis; 5*SEGMENTS output words per live word, one per
// cycle when not stalled; the next input word is not taken until the single sample
// unit has swept every segment; an expired word gives no output and does not wait
// reset: histories zero, lifetime zero, output pipeline empty
// ----------------------------------------------------------------------------
// trail_spline_tessellator
// Keeps root and tip histories and emits catmull-rom sampled trail vertices.
// ----------------------------------------------------------------------------
module trail_spline_tessellator #(
	parameter int SEGMENTS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// root_x, root_y, root_z, tip_x, tip_y, tip_z, elapsed_time, zero pad
	input  logic [tst_pkg::IN_W-1:0]     s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// upper_x, upper_y, upper_z, lower_x, lower_y, lower_z, tex_v, vertex_life
	output logic [tst_pkg::OUT_W-1:0]    m_axis_tdata,
	output logic                         m_axis_tlast,
	input  logic                         cfg_we,
	input  logic [tst_pkg::LIFE_W-1:0]   cfg_wdata
);
	import tst_pkg::*;

	tst_cmd_t                    cmd;
	tst_sts_t                    sts;
	logic [$clog2(SEGMENTS)-1:0] seg;

	tst_ctrl #(
		.SEGMENTS (SEGMENTS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd),
		.seg           (seg)
	);

	tst_datapath #(
		.SEGMENTS (SEGMENTS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.seg           (seg),
		.s_axis_tdata  (s_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

### tb/trail_spline_tessellator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trail_spline_tessellator_tb
// Drives root/tip frame words with random gaps and back-pressure and checks
// every emitted vertex word against a Catmull-Rom tessellation of the same
// point histories, across several vertex lifetime settings.
// ----------------------------------------------------------------------------
module trail_spline_tessellator_tb;
	import tst_pkg::*;

	localparam int SEGS       = 8;
	localparam int SAMPLES    = 5;
	localparam int SETTLE     = 50;
	localparam int IDLE_LIMIT = 3000;
	localparam logic [LIFE_W-1:0] LIFE_MAX = 22'd2621440;
	localparam coord_t C_MAX = 32'sh7fffffff;
	localparam coord_t C_MIN = 32'sh80000000;

	class trail_vertex_checker;
		typedef struct {
			pt_t               pt;
			logic [TEXV_W-1:0] tex_v;
			logic [LIFE_W-1:0] life;
			logic              last;
		} vertex_t;

		pt_t               hist [SEGS];
		logic [LIFE_W-1:0] lifetime;
		vertex_t           pending [$];
		int                errors;
		int                seen;

		function new();
			foreach (hist[i])
				hist[i] = '0;
			lifetime = '0;
			errors   = 0;
			seen     = 0;
		endfunction

		// catmull-rom basis at t = k/4, scaled by 128
		function int weight(int k, int j);
			int row [4];
			case (k)
				0: row = '{0, 128, 0, 0};
				1: row = '{-9, 111, 29, -3};
				2: row = '{-8, 72, 72, -8};
				3: row = '{-3, 29, 111, -9};
				default: row = '{0, 0, 128, 0};
			endcase
			return row[j];
		endfunction

		function coord_t spline_point(coord_t p0, coord_t p1, coord_t p2, coord_t p3, int k);
			longint acc;
			acc = weight(k, 0) * longint'(p0) + weight(k, 1) * longint'(p1) +
			      weight(k, 2) * longint'(p2) + weight(k, 3) * longint'(p3);
			// round half up, then saturate
			acc = (acc + 64) >>> 7;
			if (acc > longint'(C_MAX))
				return C_MAX;
			if (acc < longint'(C_MIN))
				return C_MIN;
			return coord_t'(acc);
		endfunction

		function void tessellate_frame(pt_t p, logic [LIFE_W-1:0] elapsed);
			vertex_t v;
			int a, b, d, e;
			longint life;
			for (int i = SEGS - 1; i >= 1; i--)
				hist[i] = hist[i-1];
			hist[0] = p;
			life = longint'(lifetime) - longint'(elapsed);
			// expired frames still shift the histories
			if (life <= 0)
				return;
			for (int i = 0; i < SEGS; i++) begin
				a = (i > 0) ? i - 1 : 0;
				b = i;
				d = (i + 1 < SEGS) ? i + 1 : SEGS - 1;
				e = (i + 2 < SEGS) ? i + 2 : SEGS - 1;
				for (int k = 0; k < SAMPLES; k++) begin
					for (int c = 0; c < NCOORD; c++)
						v.pt[c] = spline_point(hist[a][c], hist[b][c], hist[d][c], hist[e][c], k);
					v.tex_v = TEXV_W'(((i + 1) * 131072 + SEGS - 1) / (2 * (SEGS - 1)));
					v.life  = life[LIFE_W-1:0];
					v.last  = (i == SEGS - 1) && (k == SAMPLES - 1);
					pending.push_back(v);
				end
			end
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		task check_vertex(logic [OUT_W-1:0] d, logic tl);
			vertex_t v;
			string fname;
			coord_t got;
			seen++;
			if (pending.size() == 0) begin
				report($sformatf("word %0d arrived with nothing expected", seen));
				return;
			end
			v = pending.pop_front();
			for (int c = 0; c < NCOORD; c++) begin
				got = d[c*COORD_W +: COORD_W];
				case (c)
					0: fname = "upper_x";
					1: fname = "upper_y";
					2: fname = "upper_z";
					3: fname = "lower_x";
					4: fname = "lower_y";
					default: fname = "lower_z";
				endcase
				if (got !== v.pt[c])
					report($sformatf("word %0d %s got %0d want %0d", seen, fname, got, v.pt[c]));
			end
			if (d[PT_W +: TEXV_W] !== v.tex_v)
				report($sformatf("word %0d tex_v got %0h want %0h", seen,
				                 d[PT_W +: TEXV_W], v.tex_v));
			if (d[PT_W+TEXV_W +: LIFE_W] !== v.life)
				report($sformatf("word %0d vertex_life got %0h want %0h", seen,
				                 d[PT_W+TEXV_W +: LIFE_W], v.life));
			if (tl !== v.last)
				report($sformatf("word %0d tlast got %b want %b", seen, tl, v.last));
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	// root_x, root_y, root_z, tip_x, tip_y, tip_z, elapsed_time, zero pad
	logic [IN_W-1:0]   s_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	// upper_x, upper_y, upper_z, lower_x, lower_y, lower_z, tex_v, vertex_life
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              m_axis_tlast;
	logic              cfg_we;
	logic [LIFE_W-1:0] cfg_wdata;

	int gap_max = 8;
	int stall_max = 8;
	int idle_cycles = 0;
	pt_t walk_pt = '0;
	trail_vertex_checker tracker;

	trail_spline_tessellator #(
		.SEGMENTS(SEGS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic coord_t rand_coord(input coord_t prev);
		case ($urandom_range(0, 9))
			0: return C_MAX;
			1: return C_MIN;
			2, 3, 4: return coord_t'($urandom);
			// smooth motion from the previous point
			default: return prev + coord_t'($urandom_range(0, 1 << 19)) - coord_t'(1 << 18);
		endcase
	endfunction

	function automatic pt_t random_point();
		pt_t p;
		for (int c = 0; c < NCOORD; c++)
			p[c] = rand_coord(walk_pt[c]);
		walk_pt = p;
		return p;
	endfunction

	task automatic send_frame(input pt_t p, input logic [LIFE_W-1:0] elapsed);
		int gap;
		gap = $urandom_range(0, gap_max);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_W - PT_W - LIFE_W){1'b0}}, elapsed, p};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		tracker.tessellate_frame(p, elapsed);
	endtask

	// expired frames leave nothing to wait for, so let the block settle
	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_lifetime(input logic [LIFE_W-1:0] v);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.lifetime = v;
	endtask

	// result side
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			stall = $urandom_range(0, stall_max);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			tracker.check_vertex(m_axis_tdata, m_axis_tlast);
		if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		pt_t p;
		coord_t v;
		logic [LIFE_W-1:0] life_cur;
		logic [LIFE_W-1:0] el;
		int n_items;
		tracker = new();
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// lifetime is zero out of reset: frames only load the histories
		for (int j = 0; j < 3; j++)
			send_frame(random_point(), '0);

		write_lifetime(LIFE_MAX);
		// min/max/max/min runs push the spline past both rails
		for (int j = 0; j < 8; j++) begin
			v = (j % 4 == 0 || j % 4 == 3) ? C_MIN : C_MAX;
			p = {~v, v, ~v, v, ~v, v};
			send_frame(p, (j == 7) ? LIFE_MAX - 22'd1 : '0);
		end
		send_frame('0, LIFE_MAX);
		send_frame(random_point(), 22'd1);
		send_frame(random_point(), LIFE_MAX - 22'd1);

		write_lifetime(22'd1);
		send_frame(random_point(), '0);
		send_frame(random_point(), 22'd1);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: life_cur = '0;
				1: life_cur = LIFE_MAX;
				default: life_cur = LIFE_W'($urandom_range(1, LIFE_MAX));
			endcase
			write_lifetime(life_cur);
			gap_max   = (ph % 3 == 1 || ph == 5) ? 0 : 8;
			stall_max = (ph % 3 == 2 || ph == 5) ? 0 : 8;
			n_items   = (ph == 0) ? 6 : 36;
			for (int j = 0; j < n_items; j++) begin
				if ($urandom_range(0, 24) == 0)
					drain_results();
				if (life_cur != 0 && $urandom_range(0, 9) < 8)
					el = LIFE_W'($urandom_range(0, life_cur - 22'd1));
				else
					el = LIFE_W'($urandom_range(life_cur, LIFE_MAX));
				send_frame(random_point(), el);
			end
		end

		drain_results();
		if (tracker.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
